@@ sv/gmps_pkg.sv @@
package gmps_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;

	localparam int COL_W   = $clog2(MAX_COLUMNS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int DIM_W   = 9;
	localparam int COST_W  = 8;
	localparam int PATH_W  = 17;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [0:0] {
		REG_COLUMNS = 1'b0,
		REG_ROWS    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [COL_W-1:0]  col;
		logic              first_row;
		logic              first_col;
		logic              last;
	} cell_entry_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ sv/gmps_in_if.sv @@
interface gmps_in_if;
	import gmps_pkg::*;

	logic              valid;
	logic              ready;
	logic [COST_W-1:0] cell_cost;

	modport source (output valid, output cell_cost, input ready);
	modport sink (input valid, input cell_cost, output ready);

endinterface

@@ sv/gmps_out_if.sv @@
interface gmps_out_if;
	import gmps_pkg::*;

	logic              valid;
	logic              ready;
	logic [PATH_W-1:0] path_cost;
	logic              final_cell;

	modport source (output valid, output path_cost, output final_cell, input ready);
	modport sink (input valid, input path_cost, input final_cell, output ready);

endinterface

@@ sv/gmps_ram.sv @@
module gmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ sv/gmps_front.sv @@
module gmps_front (
	input  logic                          clk,
	input  logic                          arst_n,
	gmps_in_if.sink                       cell_in,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gmps_pkg::PADDR_W-1:0]  paddr,
	input  logic [gmps_pkg::PDATA_W-1:0]  pwdata,
	output logic [gmps_pkg::PDATA_W-1:0]  prdata,
	input  logic                          queue_full,
	output logic                          push,
	output gmps_pkg::cell_entry_t         push_entry
);
	import gmps_pkg::*;

	logic [DIM_W-1:0] columns_q;
	logic [DIM_W-1:0] rows_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             cfg_wr;
	reg_idx_t         reg_idx;
	logic             last_col;
	logic             last_row;

	assign reg_idx  = reg_idx_t'(paddr[2]);
	assign cfg_wr   = psel && penable && pwrite;
	assign last_col = (DIM_W'(col_q) + DIM_W'(1)) >= columns_q;
	assign last_row = (DIM_W'(row_q) + DIM_W'(1)) >= rows_q;

	assign cell_in.ready = !queue_full;
	assign push          = cell_in.valid && !queue_full;

	always_comb begin
		push_entry.cost      = cell_in.cell_cost;
		push_entry.col       = col_q;
		push_entry.first_row = (row_q == '0);
		push_entry.first_col = (col_q == '0);
		push_entry.last      = last_row && last_col;
	end

	always_comb begin
		case (reg_idx)
			REG_COLUMNS: prdata = PDATA_W'(columns_q);
			REG_ROWS:    prdata = PDATA_W'(rows_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= DIM_W'(1);
			rows_q    <= DIM_W'(1);
			col_q     <= '0;
			row_q     <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COLUMNS: columns_q <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_COLUMNS));
				REG_ROWS:    rows_q    <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_ROWS));
				default:     columns_q <= columns_q;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

@@ sv/gmps_queue.sv @@
module gmps_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  gmps_pkg::cell_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output gmps_pkg::cell_entry_t head_entry
);
	import gmps_pkg::*;

	cell_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/gmps_back.sv @@
module gmps_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  gmps_pkg::cell_entry_t head_entry,
	output logic                  pop,
	gmps_out_if.source            path_out
);
	import gmps_pkg::*;

	logic              adv;
	logic              v_s1;
	cell_entry_t       ent_s1;
	logic              fwd_s1;
	logic              v_s2;
	logic [PATH_W-1:0] path_s2;
	logic              final_s2;
	logic [PATH_W-1:0] best_q;
	logic [PATH_W-1:0] rd_data;
	logic [PATH_W-1:0] up;
	logic [PATH_W-1:0] opnd;
	logic [PATH_W:0]   sum;
	logic [PATH_W-1:0] best;

	assign adv = !v_s2 || path_out.ready;
	assign pop = adv && head_valid;

	gmps_ram #(
		.WIDTH(PATH_W),
		.DEPTH(MAX_COLUMNS)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (adv && v_s1),
		.wr_addr (ent_s1.col),
		.wr_data (best),
		.rd_en   (adv),
		.rd_addr (head_entry.col),
		.rd_data (rd_data)
	);

	// same column written on the edge the read was issued
	assign up = fwd_s1 ? best_q : rd_data;

	always_comb begin
		if (ent_s1.first_row && ent_s1.first_col) begin
			opnd = '0;
		end else if (ent_s1.first_row) begin
			opnd = best_q;
		end else if (ent_s1.first_col) begin
			opnd = up;
		end else begin
			opnd = (up < best_q) ? up : best_q;
		end
		sum  = (PATH_W+1)'(ent_s1.cost) + (PATH_W+1)'(opnd);
		best = sum[PATH_W] ? PATH_MAX : sum[PATH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else if (adv) begin
			v_s1   <= head_valid;
			fwd_s1 <= v_s1 && head_valid && (head_entry.col == ent_s1.col);
			v_s2   <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1 <= head_entry;
			if (v_s1) begin
				path_s2  <= best;
				final_s2 <= ent_s1.last;
				best_q   <= best;
			end
		end
	end

	assign path_out.valid      = v_s2;
	assign path_out.path_cost  = path_s2;
	assign path_out.final_cell = final_s2;

`ifndef SYNTH
	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forward flag without a word in s1");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(ent_s1))
		else $error("s1 word lost during stall");

	a_top_left: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ent_s1.first_row && ent_s1.first_col |-> best == PATH_W'(ent_s1.cost))
		else $error("top-left cell cost mismatch");

	a_pop_adv: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> adv && head_valid)
		else $error("pop while stalled or empty");
`endif

endmodule

@@ sv/grid_min_path_sum.sv @@
// least right/down path sum over a streamed grid
// cell_in carries one cell cost word per handshake, in row-major order;
// path_out returns one word per cell: the best path cost from the top-left
// cell and a final_cell flag on the bottom-right cell, where it is the answer
// columns and rows are set over the apb port (0 acts as 1, values above 256
// act as 256); any write restarts the grid at the top-left cell
// order: an accepted word goes through the queue, stage s1 and stage s2 to path_out
// throughput: one cell per cycle while path_out is not held, set by one read
// and one write of the one-row cost memory each cycle, with a forward path when
// a column is read on the edge it is written
// reset: dimensions return to 1x1, position to the top-left cell; the row
// memory is not cleared, since every entry is written before it is read
// stall: a four-word queue sits between input and compute; when path_out is
// held the pipeline freezes and cell_in.ready drops once the queue is full
module grid_min_path_sum (
	input  logic                          clk,
	input  logic                          arst_n,
	gmps_in_if.sink                       cell_in,
	gmps_out_if.source                    path_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gmps_pkg::PADDR_W-1:0]  paddr,
	input  logic [gmps_pkg::PDATA_W-1:0]  pwdata,
	output logic [gmps_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import gmps_pkg::*;

	logic        push;
	cell_entry_t push_entry;
	logic        queue_full;
	logic        pop;
	logic        head_valid;
	cell_entry_t head_entry;

	assign pready = 1'b1;

	gmps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_in    (cell_in),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	gmps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	gmps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.path_out   (path_out)
	);

endmodule
